[hdl/ajb_pkg.sv]
// ----------------------------------------------------------------------------
// ajb_pkg
// Shared constants, types and helpers for the audio jitter buffer reader.
// ----------------------------------------------------------------------------
package ajb_pkg;

  // ring geometry and field widths
  localparam int CAP_BITS        = 14;
  localparam int CAPACITY_FRAMES = 1 << CAP_BITS;
  localparam int CNT_W           = 64;
  localparam int SAMPLE_W        = 32;
  localparam int FRAME_W         = 2 * SAMPLE_W;
  localparam int PRE_W           = 15;
  localparam int REQ_W           = 7;
  localparam int TOTAL_W         = 32;
  localparam int MAX_REQUEST     = 64;
  localparam int PRE_RESET       = 4096;

  // input kind carried on tuser
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_SIL,
    ST_RD,
    ST_EMIT
  } state_t;

  // one result word handed to the output register
  typedef struct packed {
    logic                 valid;
    logic [SAMPLE_W-1:0]  left;
    logic [SAMPLE_W-1:0]  right;
    logic                 silence;
    logic                 last;
    logic [TOTAL_W-1:0]   underrun_total;
    logic [TOTAL_W-1:0]   frames_read_total;
  } result_t;

  // clamp a request to the largest run
  function automatic logic [REQ_W-1:0] sat_request(input logic [REQ_W-1:0] req);
    logic [REQ_W-1:0] lim;
    lim = REQ_W'(MAX_REQUEST);
    return (req > lim) ? lim : req;
  endfunction

  // clamp the prebuffer to the ring size
  function automatic logic [PRE_W-1:0] sat_prebuffer(input logic [PRE_W-1:0] pre);
    logic [PRE_W-1:0] lim;
    lim = PRE_W'(CAPACITY_FRAMES);
    return (pre > lim) ? lim : pre;
  endfunction

endpackage

[hdl/audio_jitter_buffer_reader.sv]
// ----------------------------------------------------------------------------
// audio_jitter_buffer_reader
// Stereo frame ring with prebuffer, overrun jump-back and underrun silence.
// ----------------------------------------------------------------------------
// An append word (tuser low) stores one frame. A read word (tuser high)
// checks the backlog in ST_CHECK, decides in ST_EVAL, then answers with its
// run of up to 64 frames: silence frames at one per cycle while the output
// register has space, stored frames alternating ST_RD and ST_EMIT, since
// ring reads are registered. The input stays closed until the last frame of
// a run has entered the output register; a waiting result does not block the
// next input word. There is no clearing pass after reset; the ring needs none.
module audio_jitter_buffer_reader
  import ajb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // in_left, in_right, request_frames, pad
  input  logic         s_axis_tuser,   // func
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // out_left, out_right, underrun_total,
                                       // frames_read_total
  output logic         m_axis_tuser,   // silence
  output logic         m_axis_tlast,   // last
  // prebuffer register
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [14:0]  cfg_data        // prebuffer_frames
);

  result_t push;
  result_t out_q;
  logic    space;

  assign cfg_ready = 1'b1;
  assign space     = !out_q.valid || m_axis_tready;

  ajb_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .func           (s_axis_tuser),
    .in_left        (s_axis_tdata[31:0]),
    .in_right       (s_axis_tdata[63:32]),
    .request_frames (s_axis_tdata[70:64]),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .space          (space),
    .push           (push)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_q.valid <= 1'b0;
    end else if (space) begin
      out_q.valid <= push.valid;
    end
    if (space && push.valid) begin
      out_q.left              <= push.left;
      out_q.right             <= push.right;
      out_q.silence           <= push.silence;
      out_q.last              <= push.last;
      out_q.underrun_total    <= push.underrun_total;
      out_q.frames_read_total <= push.frames_read_total;
    end
  end

  assign m_axis_tvalid = out_q.valid;
  assign m_axis_tdata  = {out_q.frames_read_total, out_q.underrun_total,
                          out_q.right, out_q.left};
  assign m_axis_tuser  = out_q.silence;
  assign m_axis_tlast  = out_q.last;

endmodule

[hdl/ajb_ram.sv]
// ----------------------------------------------------------------------------
// ajb_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module ajb_ram #(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/ajb_ctrl.sv]
// ----------------------------------------------------------------------------
// ajb_ctrl
// Frame counters, priming decision and read sequencer around the frame ring.
// ----------------------------------------------------------------------------
module ajb_ctrl
  import ajb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [SAMPLE_W-1:0] in_left,
  input  logic [SAMPLE_W-1:0] in_right,
  input  logic [REQ_W-1:0]    request_frames,
  // prebuffer register write
  input  logic                cfg_valid,
  input  logic [PRE_W-1:0]    cfg_data,
  // result words
  input  logic                space,
  output result_t             push
);

  state_t state, state_next;

  logic [CNT_W-1:0]   wr_cnt, wr_cnt_next;
  logic [CNT_W-1:0]   rd_cnt, rd_cnt_next;
  logic               primed, primed_next;
  logic [TOTAL_W-1:0] und_cnt, und_cnt_next;
  logic [TOTAL_W-1:0] dlv_cnt, dlv_cnt_next;
  logic [REQ_W-1:0]   cnt, cnt_next;
  logic [PRE_W-1:0]   prebuffer;

  logic               ram_we;
  logic               ram_re;
  logic [FRAME_W-1:0] ram_rdata;

  logic [CNT_W:0]     diff;
  logic [CNT_W-1:0]   avail;
  logic [PRE_W-1:0]   pre;
  logic [PRE_W-1:0]   target;
  logic [PRE_W-1:0]   n_ext;
  logic [REQ_W-1:0]   n_sat;

  // frame ring
  ajb_ram #(
    .ADDR_W (CAP_BITS),
    .DATA_W (FRAME_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_cnt[CAP_BITS-1:0]),
    .wdata ({in_right, in_left}),
    .re    (ram_re),
    .raddr (rd_cnt[CAP_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // prebuffer register
  always_ff @(posedge clk) begin
    if (rst) begin
      prebuffer <= PRE_W'(PRE_RESET);
    end else if (cfg_valid) begin
      prebuffer <= cfg_data;
    end
  end

  // backlog and thresholds
  assign diff   = {1'b0, wr_cnt} - {1'b0, rd_cnt};
  assign avail  = diff[CNT_W] ? '0 : diff[CNT_W-1:0];
  assign pre    = sat_prebuffer(prebuffer);
  assign n_ext  = PRE_W'(cnt);
  assign target = (n_ext > pre) ? n_ext : pre;
  assign n_sat  = sat_request(request_frames);

  // next state, counters and result word
  always_comb begin
    state_next   = state;
    wr_cnt_next  = wr_cnt;
    rd_cnt_next  = rd_cnt;
    primed_next  = primed;
    und_cnt_next = und_cnt;
    dlv_cnt_next = dlv_cnt;
    cnt_next     = cnt;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    in_ready     = (state == ST_IDLE);
    push         = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_APPEND) begin
            ram_we      = 1'b1;
            wr_cnt_next = wr_cnt + 1'b1;
          end else if (n_sat != '0) begin
            cnt_next   = n_sat;
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // overrun: jump back by the prebuffer distance
        if (avail > CNT_W'(CAPACITY_FRAMES)) begin
          rd_cnt_next = (wr_cnt > CNT_W'(pre)) ? wr_cnt - CNT_W'(pre) : wr_cnt;
          primed_next = 1'b1;
        end
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if ((!primed && avail < CNT_W'(target)) || avail < CNT_W'(cnt)) begin
          primed_next = 1'b0;
          state_next  = ST_SIL;
        end else begin
          primed_next = 1'b1;
          state_next  = ST_RD;
        end
      end
      ST_SIL: begin
        if (space) begin
          und_cnt_next           = und_cnt + 1'b1;
          push.valid             = 1'b1;
          push.silence           = 1'b1;
          push.last              = (cnt == REQ_W'(1));
          push.underrun_total    = und_cnt_next;
          push.frames_read_total = dlv_cnt;
          cnt_next               = cnt - 1'b1;
          if (cnt == REQ_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        ram_re      = 1'b1;
        rd_cnt_next = rd_cnt + 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        if (space) begin
          dlv_cnt_next           = dlv_cnt + 1'b1;
          push.valid             = 1'b1;
          push.left              = ram_rdata[SAMPLE_W-1:0];
          push.right             = ram_rdata[FRAME_W-1:SAMPLE_W];
          push.last              = (cnt == REQ_W'(1));
          push.underrun_total    = und_cnt;
          push.frames_read_total = dlv_cnt_next;
          cnt_next               = cnt - 1'b1;
          state_next             = (cnt == REQ_W'(1)) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counters and priming flag
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_cnt  <= '0;
      rd_cnt  <= '0;
      primed  <= 1'b0;
      und_cnt <= '0;
      dlv_cnt <= '0;
      cnt     <= '0;
    end else begin
      wr_cnt  <= wr_cnt_next;
      rd_cnt  <= rd_cnt_next;
      primed  <= primed_next;
      und_cnt <= und_cnt_next;
      dlv_cnt <= dlv_cnt_next;
      cnt     <= cnt_next;
    end
  end

  // ring writes and reads never meet in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("ring written and read in the same cycle");

  // a result word only goes out when the output register can take it
  a_push_space: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> space)
    else $error("result pushed into a full output register");

  // reads never run ahead of writes
  a_rd_behind_wr: assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= wr_cnt)
    else $error("read counter passed write counter");

  // a silent run always leaves the reader unprimed
  a_sil_unprimed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && state_next == ST_SIL) |=> !primed)
    else $error("primed after underrun decision");

endmodule
